>>> src/glc_pkg.sv
// Shared types and constants for the glyph LRU cache.
// Used by glyph_lru_cache and by its testbench.
`default_nettype none

package glc_pkg;

    localparam int ENTRIES_DEFAULT = 128;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_PURGE  = 2'd2,
        REQ_RESET  = 2'd3
    } req_t;

    typedef struct packed {
        logic        live;
        logic [31:0] stamp;
        logic [31:0] glyph;
        logic [20:0] codepoint;
        logic [15:0] font;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

`default_nettype wire

>>> src/glyph_lru_cache.sv
// Glyph LRU cache: a fully associative table of glyph handles keyed by font and codepoint.
// Depends on glc_pkg and on glc_ram, which holds the slot table.
//
// One request enters on the input channel (in_valid/in_ready) as a beat with
// req_type, font_id, codepoint and glyph_handle. Every request gives exactly one
// result beat on the output channel (out_valid/out_ready).
// Lookup, insert and purge walk all allocated slots through the single read port
// of the slot RAM, one slot per cycle; a table reset skips the walk. The block
// holds one request at a time and drops in_ready from the accepting beat until
// the result has been loaded into the output register.
// While a finished result still waits on out_ready, the next request is accepted
// and scanned; only its final update waits until the output register is free.
// Reset empties the table and clears the stamp counter; the slot RAM itself is
// not cleared, since only allocated slots are ever read.
`default_nettype none

module glyph_lru_cache #(
    parameter int ENTRIES = glc_pkg::ENTRIES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] font_id,
    input  wire logic [20:0] codepoint,
    input  wire logic [31:0] glyph_handle,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             hit,
    output logic [31:0]      glyph_found,
    output logic             evicted_valid,
    output logic [31:0]      evicted_glyph,
    output logic [7:0]       purged_count
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    glc_pkg::req_t        req_reg, req_next;
    logic [15:0]          font_reg, font_next;
    logic [20:0]          cp_reg, cp_next;
    logic [31:0]          glyph_reg, glyph_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [31:0]          stamp_reg, stamp_next;
    logic [CW-1:0]        addr_reg, addr_next;
    logic                 dv_reg, dv_next;
    logic [IW-1:0]        didx_reg, didx_next;
    logic                 match_found_reg, match_found_next;
    logic [IW-1:0]        match_idx_reg, match_idx_next;
    glc_pkg::slot_t       match_word_reg, match_word_next;
    logic                 dead_found_reg, dead_found_next;
    logic [IW-1:0]        dead_idx_reg, dead_idx_next;
    logic                 old_have_reg, old_have_next;
    logic [IW-1:0]        old_idx_reg, old_idx_next;
    logic [31:0]          old_age_reg, old_age_next;
    logic [31:0]          old_glyph_reg, old_glyph_next;
    logic [7:0]           cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg, hit_next;
    logic [31:0]          found_reg, found_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [31:0]          ev_glyph_reg, ev_glyph_next;
    logic [7:0]           purged_reg, purged_next;

    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    glc_pkg::slot_t            wr_word;
    logic [IW-1:0]             rd_addr;
    logic [glc_pkg::SLOT_W-1:0] rd_data;
    glc_pkg::slot_t            rd_word;
    logic [31:0]               age;
    logic                      load_ok;

    glc_ram #(
        .WIDTH (glc_pkg::SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_word = glc_pkg::slot_t'(rd_data);
    assign age     = stamp_reg - rd_word.stamp;
    assign load_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        font_next        = font_reg;
        cp_next          = cp_reg;
        glyph_next       = glyph_reg;
        fill_next        = fill_reg;
        stamp_next       = stamp_reg;
        addr_next        = addr_reg;
        dv_next          = 1'b0;
        didx_next        = didx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_word_next  = match_word_reg;
        dead_found_next  = dead_found_reg;
        dead_idx_next    = dead_idx_reg;
        old_have_next    = old_have_reg;
        old_idx_next     = old_idx_reg;
        old_age_next     = old_age_reg;
        old_glyph_next   = old_glyph_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        hit_next         = hit_reg;
        found_next       = found_reg;
        ev_valid_next    = ev_valid_reg;
        ev_glyph_next    = ev_glyph_reg;
        purged_next      = purged_reg;
        wr_en            = 1'b0;
        wr_addr          = didx_reg;
        wr_word          = rd_word;
        rd_addr          = addr_reg[IW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next         = glc_pkg::req_t'(req_type);
                    font_next        = font_id;
                    cp_next          = codepoint;
                    glyph_next       = glyph_handle;
                    addr_next        = '0;
                    match_found_next = 1'b0;
                    dead_found_next  = 1'b0;
                    old_have_next    = 1'b0;
                    old_age_next     = '0;
                    cnt_next         = '0;
                    if (glc_pkg::req_t'(req_type) == glc_pkg::REQ_RESET)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (addr_reg != fill_reg)
                begin
                    addr_next = addr_reg + CW'(1);
                    dv_next   = 1'b1;
                    didx_next = addr_reg[IW-1:0];
                end
                else if (!dv_reg)
                begin
                    state_next = ST_FINISH;
                end

                if (dv_reg)
                begin
                    case (req_reg)
                        glc_pkg::REQ_LOOKUP:
                        begin
                            if (rd_word.live && rd_word.font == font_reg
                                && rd_word.codepoint == cp_reg)
                            begin
                                match_found_next = 1'b1;
                                match_idx_next   = didx_reg;
                                match_word_next  = rd_word;
                            end
                        end
                        glc_pkg::REQ_INSERT:
                        begin
                            if (!rd_word.live)
                            begin
                                dead_found_next = 1'b1;
                                dead_idx_next   = didx_reg;
                            end
                            if (!old_have_reg || age > old_age_reg)
                            begin
                                old_have_next  = 1'b1;
                                old_idx_next   = didx_reg;
                                old_age_next   = age;
                                old_glyph_next = rd_word.glyph;
                            end
                        end
                        glc_pkg::REQ_PURGE:
                        begin
                            if (rd_word.live && rd_word.font == font_reg)
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = didx_reg;
                                wr_word      = rd_word;
                                wr_word.live = 1'b0;
                                if (cnt_reg != glc_pkg::COUNT_MAX)
                                begin
                                    cnt_next = cnt_reg + 8'd1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_FINISH:
            begin
                if (load_ok)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    found_next     = '0;
                    ev_valid_next  = 1'b0;
                    ev_glyph_next  = '0;
                    purged_next    = '0;
                    case (req_reg)
                        glc_pkg::REQ_LOOKUP:
                        begin
                            if (match_found_reg)
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = match_idx_reg;
                                wr_word       = match_word_reg;
                                wr_word.stamp = stamp_reg;
                                stamp_next    = stamp_reg + 32'd1;
                                hit_next      = 1'b1;
                                found_next    = match_word_reg.glyph;
                            end
                        end
                        glc_pkg::REQ_INSERT:
                        begin
                            wr_en             = 1'b1;
                            wr_word.live      = 1'b1;
                            wr_word.stamp     = stamp_reg;
                            wr_word.glyph     = glyph_reg;
                            wr_word.codepoint = cp_reg;
                            wr_word.font      = font_reg;
                            stamp_next        = stamp_reg + 32'd1;
                            if (dead_found_reg)
                            begin
                                wr_addr = dead_idx_reg;
                            end
                            else if (fill_reg != FULL)
                            begin
                                wr_addr   = fill_reg[IW-1:0];
                                fill_next = fill_reg + CW'(1);
                            end
                            else
                            begin
                                wr_addr       = old_idx_reg;
                                ev_valid_next = 1'b1;
                                ev_glyph_next = old_glyph_reg;
                            end
                        end
                        glc_pkg::REQ_PURGE:
                        begin
                            purged_next = cnt_reg;
                        end
                        default:
                        begin
                            fill_next = '0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            stamp_reg     <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            stamp_reg     <= stamp_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        font_reg        <= font_next;
        cp_reg          <= cp_next;
        glyph_reg       <= glyph_next;
        addr_reg        <= addr_next;
        didx_reg        <= didx_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        match_word_reg  <= match_word_next;
        dead_found_reg  <= dead_found_next;
        dead_idx_reg    <= dead_idx_next;
        old_have_reg    <= old_have_next;
        old_idx_reg     <= old_idx_next;
        old_age_reg     <= old_age_next;
        old_glyph_reg   <= old_glyph_next;
        cnt_reg         <= cnt_next;
        hit_reg         <= hit_next;
        found_reg       <= found_next;
        ev_valid_reg    <= ev_valid_next;
        ev_glyph_reg    <= ev_glyph_next;
        purged_reg      <= purged_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign glyph_found   = found_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_glyph = ev_glyph_reg;
    assign purged_count  = purged_reg;

endmodule

`default_nettype wire

>>> src/glc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; width and depth come from its parameters.
`default_nettype none

module glc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/glc_checker.sv
// Port-level checker for glyph_lru_cache, attached to every instance by a bind.
// Depends only on the top level's ports.
`default_nettype none

module glc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        hit,
    input wire logic [31:0] glyph_found,
    input wire logic        evicted_valid,
    input wire logic [31:0] evicted_glyph,
    input wire logic [7:0]  purged_count
);

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an input beat");

    a_hit_or_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted_valid))
        else $error("result reports both a hit and an eviction");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> glyph_found == 32'd0)
        else $error("glyph_found is nonzero without a hit");

    a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_glyph == 32'd0)
        else $error("evicted_glyph is nonzero without an eviction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(glyph_found)
            && $stable(purged_count))
        else $error("stalled result beat changed");

endmodule

bind glyph_lru_cache glc_checker u_glc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .glyph_found   (glyph_found),
    .evicted_valid (evicted_valid),
    .evicted_glyph (evicted_glyph),
    .purged_count  (purged_count)
);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for glyph_lru_cache: a directed table, then random beats under
// several idle and stall patterns, checked against a cycle-free model of the slot table,
// or typed rows' fixed results. Depends on glc_pkg and the glyph_lru_cache RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = glc_pkg::ENTRIES_DEFAULT;
    localparam int LIMIT = 1_000_000;
    localparam int KEYS = 40;
    localparam int RAND_BEATS = 250;

    typedef struct packed {
        glc_pkg::req_t op;
        logic [15:0]   font;
        logic [20:0]   cp;
        logic [31:0]   glyph;
    } cache_req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] glyph_found;
        logic        evicted_valid;
        logic [31:0] evicted_glyph;
        logic [7:0]  purged_count;
    } cache_result_t;

    typedef struct packed {
        cache_req_t    req;
        logic          typed;
        cache_result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [15:0] font_id;
    logic [20:0] codepoint;
    logic [31:0] glyph_handle;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [31:0] glyph_found;
    logic        evicted_valid;
    logic [31:0] evicted_glyph;
    logic [7:0]  purged_count;

    logic [15:0] tbl_font [DEPTH];
    logic [20:0] tbl_cp [DEPTH];
    logic [31:0] tbl_glyph [DEPTH];
    logic [31:0] tbl_stamp [DEPTH];
    logic        tbl_live [DEPTH];
    int          tbl_fill;
    logic [31:0] stamp_now;

    cache_result_t pending_results[$];
    stim_row_t     directed_rows[$];

    int fail_count = 0;
    int cycle_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int evictions_seen = 0;
    int purged_seen = 0;

    glyph_lru_cache u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .font_id      (font_id),
        .codepoint    (codepoint),
        .glyph_handle (glyph_handle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .glyph_found  (glyph_found),
        .evicted_valid(evicted_valid),
        .evicted_glyph(evicted_glyph),
        .purged_count (purged_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cache_result_t glyph_cache_apply(cache_req_t r);
        cache_result_t res;
        int            pick;
        int            cnt;
        logic [31:0]   age;
        logic [31:0]   best_age;
        res = '0;
        pick = -1;
        case (r.op)
            glc_pkg::REQ_LOOKUP:
            begin
                for (int s = tbl_fill - 1; s >= 0; s--)
                    if (pick < 0 && tbl_live[s] && tbl_font[s] == r.font && tbl_cp[s] == r.cp)
                        pick = s;
                if (pick >= 0)
                begin
                    tbl_stamp[pick] = stamp_now;
                    stamp_now = stamp_now + 32'd1;
                    res.hit = 1'b1;
                    res.glyph_found = tbl_glyph[pick];
                end
            end
            glc_pkg::REQ_INSERT:
            begin
                for (int s = tbl_fill - 1; s >= 0; s--)
                    if (pick < 0 && !tbl_live[s])
                        pick = s;
                if (pick < 0 && tbl_fill < DEPTH)
                begin
                    pick = tbl_fill;
                    tbl_fill++;
                end
                else if (pick < 0)
                begin
                    pick = 0;
                    best_age = stamp_now - tbl_stamp[0];
                    for (int s = 1; s < tbl_fill; s++)
                    begin
                        age = stamp_now - tbl_stamp[s];
                        if (age > best_age)
                        begin
                            best_age = age;
                            pick = s;
                        end
                    end
                    res.evicted_valid = 1'b1;
                    res.evicted_glyph = tbl_glyph[pick];
                end
                tbl_font[pick] = r.font;
                tbl_cp[pick] = r.cp;
                tbl_glyph[pick] = r.glyph;
                tbl_live[pick] = 1'b1;
                tbl_stamp[pick] = stamp_now;
                stamp_now = stamp_now + 32'd1;
            end
            glc_pkg::REQ_PURGE:
            begin
                cnt = 0;
                for (int s = 0; s < tbl_fill; s++)
                    if (tbl_live[s] && tbl_font[s] == r.font)
                    begin
                        tbl_live[s] = 1'b0;
                        if (cnt < glc_pkg::COUNT_MAX)
                            cnt++;
                    end
                res.purged_count = cnt[7:0];
            end
            default:
                tbl_fill = 0;
        endcase
        return res;
    endfunction

    task automatic add_row(glc_pkg::req_t op, logic [15:0] f, logic [20:0] c,
                           logic [31:0] g, logic typed, cache_result_t want);
        stim_row_t row;
        row.req = '{op: op, font: f, cp: c, glyph: g};
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_beat(cache_req_t r, logic typed, cache_result_t want);
        cache_result_t predicted;
        in_valid <= 1'b1;
        req_type <= r.op;
        font_id <= r.font;
        codepoint <= r.cp;
        glyph_handle <= r.glyph;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = glyph_cache_apply(r);
        pending_results.push_back(typed ? want : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        cache_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            hits_seen += int'(hit);
            evictions_seen += int'(evicted_valid);
            purged_seen += int'(purged_count);
            if (pending_results.size() == 0)
            begin
                $error("result beat arrived with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(hit));
                check_field("glyph_found", want.glyph_found, glyph_found);
                check_field("evicted_valid", 32'(want.evicted_valid), 32'(evicted_valid));
                check_field("evicted_glyph", want.evicted_glyph, evicted_glyph);
                check_field("purged_count", 32'(want.purged_count), 32'(purged_count));
            end
        end
    end

    initial
    begin
        cache_req_t    rq;
        cache_result_t none;
        cache_result_t two_purged;
        logic [15:0]   font_pool [8];
        logic [15:0]   key_font [KEYS];
        logic [20:0]   key_cp [KEYS];
        int            roll;
        int            k;

        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        req_type = glc_pkg::REQ_LOOKUP;
        font_id = '0;
        codepoint = '0;
        glyph_handle = '0;
        tbl_fill = 0;
        stamp_now = '0;
        none = '0;
        two_purged = '0;
        two_purged.purged_count = 8'd2;

        // Empty table, then key extremes, font zero and handle zero.
        add_row(glc_pkg::REQ_LOOKUP, 16'hFFFF, 21'h1FFFFF, 32'h0, 1'b1, none);
        add_row(glc_pkg::REQ_PURGE, 16'h0001, 21'h0, 32'h0, 1'b1, none);
        add_row(glc_pkg::REQ_INSERT, 16'hFFFF, 21'h1FFFFF, 32'hFFFFFFFF, 1'b1, none);
        add_row(glc_pkg::REQ_INSERT, 16'h0000, 21'h0, 32'h0, 1'b1, none);
        add_row(glc_pkg::REQ_INSERT, 16'h0001, 21'h10FFFF, 32'h12345678, 1'b1, none);
        add_row(glc_pkg::REQ_LOOKUP, 16'hFFFF, 21'h1FFFFF, 32'h0, 1'b0, none);
        add_row(glc_pkg::REQ_LOOKUP, 16'h0000, 21'h0, 32'h0, 1'b0, none);
        add_row(glc_pkg::REQ_LOOKUP, 16'hFFFF, 21'h0, 32'h0, 1'b0, none);
        add_row(glc_pkg::REQ_LOOKUP, 16'h0000, 21'h1FFFFF, 32'h0, 1'b0, none);
        // A duplicate key must resolve to the newer slot.
        add_row(glc_pkg::REQ_INSERT, 16'h0001, 21'h10FFFF, 32'hAAAA5555, 1'b0, none);
        add_row(glc_pkg::REQ_LOOKUP, 16'h0001, 21'h10FFFF, 32'h0, 1'b0, none);
        add_row(glc_pkg::REQ_PURGE, 16'h0001, 21'h0, 32'h0, 1'b1, two_purged);
        add_row(glc_pkg::REQ_LOOKUP, 16'h0001, 21'h10FFFF, 32'h0, 1'b0, none);
        add_row(glc_pkg::REQ_PURGE, 16'h0001, 21'h0, 32'h0, 1'b1, none);
        // Dead slots are reused newest first before the table grows.
        add_row(glc_pkg::REQ_INSERT, 16'h1234, 21'h41, 32'h55555555, 1'b0, none);
        add_row(glc_pkg::REQ_INSERT, 16'h1234, 21'h42, 32'h66666666, 1'b0, none);
        add_row(glc_pkg::REQ_INSERT, 16'h1234, 21'h43, 32'h77777777, 1'b0, none);
        add_row(glc_pkg::REQ_PURGE, 16'h0000, 21'h0, 32'h0, 1'b0, none);
        add_row(glc_pkg::REQ_LOOKUP, 16'h1234, 21'h42, 32'h0, 1'b0, none);
        add_row(glc_pkg::REQ_RESET, 16'h0000, 21'h0, 32'h0, 1'b1, none);
        add_row(glc_pkg::REQ_LOOKUP, 16'hFFFF, 21'h1FFFFF, 32'h0, 1'b1, none);
        add_row(glc_pkg::REQ_INSERT, 16'h8000, 21'h100000, 32'h80000001, 1'b1, none);
        add_row(glc_pkg::REQ_LOOKUP, 16'h8000, 21'h100000, 32'h0, 1'b0, none);

        for (int i = 0; i < 8; i++)
            font_pool[i] = 16'($urandom_range(0, 65535));
        font_pool[0] = 16'h0001;
        font_pool[1] = 16'hFFFF;
        for (int i = 0; i < KEYS; i++)
        begin
            key_font[i] = font_pool[$urandom_range(0, 7)];
            key_cp[i] = 21'($urandom_range(0, 21'h1FFFFF));
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 72; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 72; end
                default: begin gap_pct = 30; stall_pct = 30; end
            endcase
            if (ph == 2)
            begin
                in_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge clk);
            end
            for (int n = 0; n < RAND_BEATS; n++)
            begin
                while ($urandom_range(0, 99) < gap_pct)
                begin
                    in_valid <= 1'b0;
                    @(negedge clk);
                end
                roll = $urandom_range(0, 999);
                k = $urandom_range(0, KEYS - 1);
                rq.font = key_font[k];
                rq.cp = key_cp[k];
                rq.glyph = $urandom;
                if ($urandom_range(0, 99) < 15)
                begin
                    rq.font = 16'($urandom_range(0, 65535));
                    rq.cp = 21'($urandom_range(0, 21'h1FFFFF));
                end
                if (roll < 2)
                    rq.op = glc_pkg::REQ_RESET;
                else if (roll < 27)
                begin
                    rq.op = glc_pkg::REQ_PURGE;
                    if ($urandom_range(0, 1) == 0)
                        rq.font = font_pool[$urandom_range(0, 7)];
                end
                else if (roll < 580)
                    rq.op = glc_pkg::REQ_INSERT;
                else
                    rq.op = glc_pkg::REQ_LOOKUP;
                send_beat(rq, 1'b0, none);
            end
        end

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DEPTH + 8) @(posedge clk);

        $display("Ran %0d requests and checked %0d result beats over four idle patterns.",
                 requests_sent, results_seen);
        $display("Saw %0d hits, %0d evictions and %0d purged entries.",
                 hits_seen, evictions_seen, purged_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
